@@ rtl/core/tolerant_point_index_table_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Tolerant point index table - assertion macros
// Shared wrappers for the concurrent assertions of the checker.
// ----------------------------------------------------------------------------
`ifndef TOLERANT_POINT_INDEX_TABLE_UNIT_DEFINES_SVH
`define TOLERANT_POINT_INDEX_TABLE_UNIT_DEFINES_SVH

// Checked only while the reset is released.
`define TPIT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, during reset as well.
`define TPIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/tpit_pkg.sv @@
// ----------------------------------------------------------------------------
// Tolerant point index table - package
// Sizes, codes and shared types of the point table.
// ----------------------------------------------------------------------------
`default_nettype none

package tpit_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int COORD_W     = 32;
  localparam int TOL_W       = 16;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_LOCATE = 2'd2
  } tpit_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_FOUND     = 3'd0,
    STAT_ADDED     = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_AMBIGUOUS = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_BAD_INDEX = 3'd5
  } tpit_status_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_LOOK = 5'b00100,
    ST_DONE = 5'b01000,
    ST_EMIT = 5'b10000
  } tpit_state_e;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [COORD_W-1:0] wx;
    logic [COORD_W-1:0] wy;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } tpit_ram_req_t;

endpackage

`default_nettype wire

@@ rtl/core/tpit_point_ram.sv @@
// ----------------------------------------------------------------------------
// Tolerant point index table - point memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tpit_point_ram (
  input  wire logic                           clk_i,
  input  wire tpit_pkg::tpit_ram_req_t        req_i,
  output logic        [tpit_pkg::COORD_W-1:0] rdata_x_o,
  output logic        [tpit_pkg::COORD_W-1:0] rdata_y_o
);

  logic [tpit_pkg::COORD_W-1:0] mem_x [tpit_pkg::TABLE_DEPTH];
  logic [tpit_pkg::COORD_W-1:0] mem_y [tpit_pkg::TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_x[req_i.waddr] <= req_i.wx;
      mem_y[req_i.waddr] <= req_i.wy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_x_o <= mem_x[req_i.raddr];
      rdata_y_o <= mem_y[req_i.raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tpit_box_match.sv @@
// ----------------------------------------------------------------------------
// Tolerant point index table - box match
// Strict square tolerance test between a stored point and the query point.
// ----------------------------------------------------------------------------
`default_nettype none

module tpit_box_match (
  input  wire logic signed [tpit_pkg::COORD_W-1:0] entry_x_i,
  input  wire logic signed [tpit_pkg::COORD_W-1:0] entry_y_i,
  input  wire logic signed [tpit_pkg::COORD_W-1:0] query_x_i,
  input  wire logic signed [tpit_pkg::COORD_W-1:0] query_y_i,
  input  wire logic        [tpit_pkg::TOL_W-1:0]   tol_i,
  output logic                                     hit_o
);

  localparam int DIFF_W = tpit_pkg::COORD_W + 1;

  // The difference is taken one bit wider, so it never wraps.
  function automatic logic near(input logic [tpit_pkg::COORD_W-1:0] a,
                                input logic [tpit_pkg::COORD_W-1:0] b,
                                input logic [tpit_pkg::TOL_W-1:0]   t);
    logic signed [DIFF_W-1:0] d;
    logic        [DIFF_W-1:0] mag;
    d   = $signed({a[tpit_pkg::COORD_W-1], a}) - $signed({b[tpit_pkg::COORD_W-1], b});
    mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return mag < DIFF_W'(t);
  endfunction

  assign hit_o = near(entry_x_i, query_x_i, tol_i) && near(entry_y_i, query_y_i, tol_i);

endmodule

`default_nettype wire

@@ rtl/core/tpit_sequencer.sv @@
// ----------------------------------------------------------------------------
// Tolerant point index table - sequencer
// Scans the point memory for each insert or find, reads one entry for a
// locate, appends new points and holds the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tpit_sequencer (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic        [tpit_pkg::OP_W-1:0]      op_i,
  input  wire logic signed [tpit_pkg::COORD_W-1:0]   x_i,
  input  wire logic signed [tpit_pkg::COORD_W-1:0]   y_i,
  input  wire logic        [tpit_pkg::IDX_W-1:0]     idx_i,
  input  wire logic        [tpit_pkg::TOL_W-1:0]     tol_i,
  output tpit_pkg::tpit_ram_req_t                    ram_req_o,
  input  wire logic signed [tpit_pkg::COORD_W-1:0]   ram_x_i,
  input  wire logic signed [tpit_pkg::COORD_W-1:0]   ram_y_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic             [tpit_pkg::IDX_W-1:0]     res_index_o,
  output logic signed      [tpit_pkg::COORD_W-1:0]   res_x_o,
  output logic signed      [tpit_pkg::COORD_W-1:0]   res_y_o,
  output logic             [tpit_pkg::STATUS_W-1:0]  status_o
);

  tpit_pkg::tpit_state_e state_q, state_d;

  logic [tpit_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [tpit_pkg::CNT_W-1:0] ptr_q, ptr_d;
  logic [tpit_pkg::CNT_W-1:0] tag_q, tag_d;
  logic                       rd_vld_q, rd_vld_d;
  logic [1:0]                 hits_q, hits_d;
  logic [tpit_pkg::IDX_W-1:0] first_q, first_d;

  logic        [tpit_pkg::OP_W-1:0]    op_q, op_d;
  logic signed [tpit_pkg::COORD_W-1:0] qx_q, qx_d, qy_q, qy_d;
  logic        [tpit_pkg::IDX_W-1:0]   idx_q, idx_d;

  logic        [tpit_pkg::IDX_W-1:0]   res_idx_q, res_idx_d;
  logic signed [tpit_pkg::COORD_W-1:0] res_x_q, res_x_d, res_y_q, res_y_d;
  tpit_pkg::tpit_status_e              res_st_q, res_st_d;

  logic                                out_vld_q, out_vld_d;
  logic        [tpit_pkg::IDX_W-1:0]   out_idx_q, out_idx_d;
  logic signed [tpit_pkg::COORD_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  tpit_pkg::tpit_status_e              out_st_q, out_st_d;

  logic hit;

  tpit_box_match u_match (
    .entry_x_i (ram_x_i),
    .entry_y_i (ram_y_i),
    .query_x_i (qx_q),
    .query_y_i (qy_q),
    .tol_i     (tol_i),
    .hit_o     (hit)
  );

  assign in_ready_o = (state_q == tpit_pkg::ST_IDLE);

  // Reads only ever touch entries below the fill count and the single write
  // goes to the entry at the fill count after the scan has drained, so read
  // and write of the same entry never overlap.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    tag_d     = ptr_q;
    hits_d    = hits_q;
    first_d   = first_q;
    op_d      = op_q;
    qx_d      = qx_q;
    qy_d      = qy_q;
    idx_d     = idx_q;
    res_idx_d = res_idx_q;
    res_x_d   = res_x_q;
    res_y_d   = res_y_q;
    res_st_d  = res_st_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_idx_d = out_idx_q;
    out_x_d   = out_x_q;
    out_y_d   = out_y_q;
    out_st_d  = out_st_q;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = cnt_q[tpit_pkg::IDX_W-1:0];
    ram_req_o.wx    = qx_q;
    ram_req_o.wy    = qy_q;
    ram_req_o.re    = 1'b0;
    ram_req_o.raddr = ptr_q[tpit_pkg::IDX_W-1:0];

    unique case (state_q)
      tpit_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_i;
          qx_d      = x_i;
          qy_d      = y_i;
          idx_d     = idx_i;
          res_idx_d = '0;
          res_x_d   = '0;
          res_y_d   = '0;
          res_st_d  = tpit_pkg::STAT_BAD_INDEX;
          unique case (op_i)
            tpit_pkg::OP_INSERT, tpit_pkg::OP_FIND: begin
              hits_d  = '0;
              first_d = '0;
              ptr_d   = '0;
              state_d = (cnt_q == '0) ? tpit_pkg::ST_DONE : tpit_pkg::ST_SCAN;
            end
            tpit_pkg::OP_LOCATE: begin
              if ({1'b0, idx_i} < cnt_q) begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = idx_i;
                state_d         = tpit_pkg::ST_LOOK;
              end else begin
                state_d = tpit_pkg::ST_EMIT;
              end
            end
            default: begin
              state_d = tpit_pkg::ST_EMIT;
            end
          endcase
        end
      end

      tpit_pkg::ST_SCAN: begin
        if (ptr_q < cnt_q) begin
          ram_req_o.re = 1'b1;
          ptr_d        = ptr_q + 1'b1;
        end
        if (rd_vld_q && hit) begin
          if (hits_q == 2'd0) begin
            first_d = tag_q[tpit_pkg::IDX_W-1:0];
          end
          if (hits_q != 2'd2) begin
            hits_d = hits_q + 1'b1;
          end
        end
        if (rd_vld_q && (tag_q == cnt_q - 1'b1)) begin
          state_d = tpit_pkg::ST_DONE;
        end
      end

      tpit_pkg::ST_LOOK: begin
        res_idx_d = idx_q;
        res_x_d   = ram_x_i;
        res_y_d   = ram_y_i;
        res_st_d  = tpit_pkg::STAT_FOUND;
        state_d   = tpit_pkg::ST_EMIT;
      end

      tpit_pkg::ST_DONE: begin
        priority if (hits_q == 2'd1) begin
          res_idx_d = first_q;
          res_st_d  = tpit_pkg::STAT_FOUND;
        end else if (hits_q != 2'd0) begin
          res_st_d = tpit_pkg::STAT_AMBIGUOUS;
        end else if (op_q == tpit_pkg::OP_FIND) begin
          res_st_d = tpit_pkg::STAT_NOT_FOUND;
        end else if (cnt_q >= tpit_pkg::CNT_W'(tpit_pkg::TABLE_DEPTH)) begin
          res_st_d = tpit_pkg::STAT_FULL;
        end else begin
          ram_req_o.we = 1'b1;
          res_idx_d    = cnt_q[tpit_pkg::IDX_W-1:0];
          res_st_d     = tpit_pkg::STAT_ADDED;
          cnt_d        = cnt_q + 1'b1;
        end
        state_d = tpit_pkg::ST_EMIT;
      end

      tpit_pkg::ST_EMIT: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          out_idx_d = res_idx_q;
          out_x_d   = res_x_q;
          out_y_d   = res_y_q;
          out_st_d  = res_st_q;
          state_d   = tpit_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tpit_pkg::ST_IDLE;
      end
    endcase

    rd_vld_d = (state_q == tpit_pkg::ST_SCAN) && ram_req_o.re;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tpit_pkg::ST_IDLE;
      cnt_q     <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      hits_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ptr_q     <= ptr_d;
      rd_vld_q  <= rd_vld_d;
      hits_q    <= hits_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q     <= tag_d;
    first_q   <= first_d;
    op_q      <= op_d;
    qx_q      <= qx_d;
    qy_q      <= qy_d;
    idx_q     <= idx_d;
    res_idx_q <= res_idx_d;
    res_x_q   <= res_x_d;
    res_y_q   <= res_y_d;
    res_st_q  <= res_st_d;
    out_idx_q <= out_idx_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
    out_st_q  <= out_st_d;
  end

  assign out_valid_o = out_vld_q;
  assign res_index_o = out_idx_q;
  assign res_x_o     = out_x_q;
  assign res_y_o     = out_y_q;
  assign status_o    = out_st_q;

endmodule

`default_nettype wire

@@ rtl/core/tolerant_point_index_table_unit.sv @@
// ----------------------------------------------------------------------------
// Tolerant point index table - top level
// Request stream in, one result per request out, one tolerance register.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel (operation in tuser, point and index
// in tdata); every request gives exactly one result transaction on m_axis
// (status in tuser, index and coordinates in tdata). cfg_we_i writes the
// half tolerance; write it only while no request is in flight.
// The block works on one request at a time. An insert or find reads every
// stored entry through the single read port of the point memory, one entry
// per cycle; the table holds up to 1024 points. A location lookup reads a
// single entry; an out-of-range lookup or an unused operation reads none.
// A new request is taken as soon as the previous one has been placed in the
// output register, even if the receiver has not yet taken that result; while
// the receiver stalls with a result still held, the next result waits and
// s_axis_tready stays low.
// Reset empties the table at once (fill count to zero, no clearing pass),
// sets the half tolerance to 1 and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module tolerant_point_index_table_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,    // half_tolerance
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,   // x_coord[31:0], y_coord[63:32],
                                           // entry_index[73:64], zero pad
  input  wire logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // result_index[9:0], result_x[41:10],
                                           // result_y[73:42], zero pad
  output logic [2:0]       m_axis_tuser    // status[2:0]
);

  logic [tpit_pkg::TOL_W-1:0] tol_q;

  tpit_pkg::tpit_ram_req_t             ram_req;
  logic signed [tpit_pkg::COORD_W-1:0] ram_x, ram_y;

  logic        [tpit_pkg::IDX_W-1:0]   res_index;
  logic signed [tpit_pkg::COORD_W-1:0] res_x, res_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= tpit_pkg::TOL_W'(1);
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  tpit_point_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rdata_x_o (ram_x),
    .rdata_y_o (ram_y)
  );

  tpit_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .x_i         (s_axis_tdata[31:0]),
    .y_i         (s_axis_tdata[63:32]),
    .idx_i       (s_axis_tdata[73:64]),
    .tol_i       (tol_q),
    .ram_req_o   (ram_req),
    .ram_x_i     (ram_x),
    .ram_y_i     (ram_y),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_index_o (res_index),
    .res_x_o     (res_x),
    .res_y_o     (res_y),
    .status_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {6'b0, res_y, res_x, res_index};

endmodule

`default_nettype wire

@@ rtl/core/tpit_checker.sv @@
// ----------------------------------------------------------------------------
// Tolerant point index table - port checker
// Watches the ports of the top level and flags illegal behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tolerant_point_index_table_unit_defines.svh"

module tpit_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic [15:0] cfg_wdata_i,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [79:0] s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  // A result whose status is not FOUND carries no coordinates.
  `TPIT_ASSERT(a_coords_zero, clk_i, rst_ni, (m_axis_tvalid && (m_axis_tuser != tpit_pkg::STAT_FOUND) |-> (m_axis_tdata[73:10] == '0)), "coordinates set on a result without a match")

  // Failed requests report index zero.
  `TPIT_ASSERT(a_index_zero, clk_i, rst_ni, (m_axis_tvalid && ((m_axis_tuser == tpit_pkg::STAT_NOT_FOUND) || (m_axis_tuser == tpit_pkg::STAT_AMBIGUOUS) || (m_axis_tuser == tpit_pkg::STAT_FULL) || (m_axis_tuser == tpit_pkg::STAT_BAD_INDEX)) |-> (m_axis_tdata[9:0] == '0)), "non-zero index on a failed request")

  // Only one request is worked on at a time.
  `TPIT_ASSERT(a_one_in_flight, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready |=> !s_axis_tready), "request taken while another is in flight")

  // A stalled result holds.
  `TPIT_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

  // No result is offered while reset is applied.
  `TPIT_ASSERT_ALWAYS(a_reset_quiet, clk_i, (!rst_ni |-> !m_axis_tvalid), "result valid during reset")

endmodule

bind tolerant_point_index_table_unit tpit_checker u_tpit_checker (.*);

`default_nettype wire
